>>> hdl/weighted_corner_cutting_defines.svh
// Assertion macros shared by the weighted corner cutting RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef WEIGHTED_CORNER_CUTTING_DEFINES_SVH
`define WEIGHTED_CORNER_CUTTING_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define WCC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define WCC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/wcc_pkg.sv
// Shared constants and types for the weighted corner cutting block.
// No dependencies; every RTL module imports this package.
`default_nettype none

package wcc_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int WEIGHT_WIDTH = 8;
  localparam int NUM_AXES     = 3;
  localparam int AXIS_W       = $clog2(NUM_AXES);

  // Radix-16 restoring divider: four quotient bits per cycle.
  localparam int DIV_DIGITS = 4;
  localparam int DIV_NUM_W  = COORD_WIDTH + WEIGHT_WIDTH;
  localparam int DIV_STEPS  = (DIV_NUM_W + DIV_DIGITS - 1) / DIV_DIGITS;
  localparam int DIV_PAD_W  = DIV_STEPS * DIV_DIGITS;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
  localparam int DEN_W      = WEIGHT_WIDTH + 2;

  localparam int SEGQ_DEPTH = 4;
  localparam int SEGQ_AW    = $clog2(SEGQ_DEPTH);
  localparam int SEGQ_CW    = $clog2(SEGQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_CURVE = '0;

  typedef logic [NUM_AXES-1:0][COORD_WIDTH-1:0] point_t;

  // One segment to cut, from the left point to the right point.
  typedef struct packed {
    point_t                  lpt;
    logic [WEIGHT_WIDTH-1:0] lw;
    point_t                  rpt;
    logic [WEIGHT_WIDTH-1:0] rw;
    logic                    last;
  } seg_t;

  // Up to two segments written into the segment queue in one cycle.
  typedef struct packed {
    logic [1:0] n;
    seg_t       first;
    seg_t       second;
  } segq_wr_t;

  typedef struct packed {
    point_t                  pt;
    logic [WEIGHT_WIDTH-1:0] w;
    logic                    run_end;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/weighted_corner_cutting.sv
// Top level of the weighted corner cutting block.
// Depends on wcc_pkg, wcc_front, wcc_seg_queue and wcc_back.
//
// One pass of weighted Chaikin corner cutting over a stream of 3D points in
// signed Q16.8, each with an 8-bit weight (0 counts as 1). Every segment from
// the previous point to the current one yields two result beats, the first
// carrying the left weight and the second the right one; the last beat caused
// by an input beat has out_run_end set. With closed_curve set, the point marked
// last also cuts the closing segment back to the first point, so one input beat
// gives 0, 2 or 4 result beats. Input beats are taken whenever the segment
// queue has room for two segments, also while results wait to be popped. A
// segment passes through the cutting engine in steps: a fetch from the segment
// queue, then per axis the difference, the multiply and the shared divider,
// which retires four quotient bits per cycle, and last the queueing of its
// two points, each of which waits for room in the result queue. The block
// needs no start-up pass after reset.
`default_nettype none

module weighted_corner_cutting import wcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic [COORD_WIDTH-1:0]  in_x_coord,
  input  logic [COORD_WIDTH-1:0]  in_y_coord,
  input  logic [COORD_WIDTH-1:0]  in_z_coord,
  input  logic [WEIGHT_WIDTH-1:0] in_point_weight,
  input  logic                    in_last_point,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_WIDTH-1:0]  out_x,
  output logic [COORD_WIDTH-1:0]  out_y,
  output logic [COORD_WIDTH-1:0]  out_z,
  output logic [WEIGHT_WIDTH-1:0] out_weight,
  output logic                    out_run_end
);

  segq_wr_t segq_wr;
  logic     segq_no_room;
  logic     segq_pop;
  logic     segq_empty;
  seg_t     segq_head;

  wcc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .in_point_weight (in_point_weight),
    .in_last_point   (in_last_point),
    .segq_no_room    (segq_no_room),
    .segq_wr         (segq_wr)
  );

  wcc_seg_queue u_segq (
    .clk          (clk),
    .rst_n        (rst_n),
    .segq_wr      (segq_wr),
    .segq_no_room (segq_no_room),
    .segq_pop     (segq_pop),
    .segq_empty   (segq_empty),
    .segq_head    (segq_head)
  );

  wcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .segq_head   (segq_head),
    .segq_empty  (segq_empty),
    .segq_pop    (segq_pop),
    .empty       (empty),
    .pop         (pop),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_z       (out_z),
    .out_weight  (out_weight),
    .out_run_end (out_run_end)
  );

endmodule

`default_nettype wire

>>> hdl/wcc_front.sv
// Front end: configuration register, input beat acceptance and polyline state.
// Turns each input beat into zero, one or two segments. Depends on wcc_pkg.
`default_nettype none

module wcc_front import wcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    push,
  output logic                    full,
  input  logic [COORD_WIDTH-1:0]  in_x_coord,
  input  logic [COORD_WIDTH-1:0]  in_y_coord,
  input  logic [COORD_WIDTH-1:0]  in_z_coord,
  input  logic [WEIGHT_WIDTH-1:0] in_point_weight,
  input  logic                    in_last_point,
  input  logic                    segq_no_room,
  output segq_wr_t                segq_wr
);

  logic                    closed_r, closed_nxt;
  logic                    have_prev_r, have_prev_nxt;
  point_t                  prev_pt_r, prev_pt_nxt;
  logic [WEIGHT_WIDTH-1:0] prev_w_r, prev_w_nxt;
  point_t                  start_pt_r, start_pt_nxt;
  logic [WEIGHT_WIDTH-1:0] start_w_r, start_w_nxt;

  logic [CFG_IDX_W-1:0]    reg_idx;
  logic                    cfg_we;
  logic                    accept;
  logic                    closing;
  point_t                  cur_pt;
  logic [WEIGHT_WIDTH-1:0] cur_w;
  seg_t                    seg_prev;
  seg_t                    seg_close;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_we  = psel & penable & pwrite & pready;
  assign prdata  = (reg_idx == REG_CLOSED_CURVE) ? CFG_DATA_W'(closed_r) : '0;

  assign full   = segq_no_room;
  assign accept = push & ~segq_no_room;

  assign cur_pt[0] = in_x_coord;
  assign cur_pt[1] = in_y_coord;
  assign cur_pt[2] = in_z_coord;
  assign cur_w     = (in_point_weight == '0) ? WEIGHT_WIDTH'(1) : in_point_weight;
  assign closing   = in_last_point & closed_r;

  // On the first point of a run the point itself is the start of the loop.
  always_comb begin
    seg_prev.lpt  = prev_pt_r;
    seg_prev.lw   = prev_w_r;
    seg_prev.rpt  = cur_pt;
    seg_prev.rw   = cur_w;
    seg_prev.last = ~closing;

    seg_close.lpt  = cur_pt;
    seg_close.lw   = cur_w;
    seg_close.rpt  = have_prev_r ? start_pt_r : cur_pt;
    seg_close.rw   = have_prev_r ? start_w_r : cur_w;
    seg_close.last = 1'b1;

    segq_wr.first  = have_prev_r ? seg_prev : seg_close;
    segq_wr.second = seg_close;
    if (accept) begin
      segq_wr.n = 2'(have_prev_r) + 2'(closing);
    end else begin
      segq_wr.n = 2'd0;
    end
  end

  always_comb begin
    closed_nxt    = closed_r;
    have_prev_nxt = have_prev_r;
    prev_pt_nxt   = prev_pt_r;
    prev_w_nxt    = prev_w_r;
    start_pt_nxt  = start_pt_r;
    start_w_nxt   = start_w_r;
    if (cfg_we && reg_idx == REG_CLOSED_CURVE) begin
      closed_nxt = pwdata[0];
    end
    if (accept) begin
      if (!have_prev_r) begin
        start_pt_nxt = cur_pt;
        start_w_nxt  = cur_w;
      end
      if (in_last_point) begin
        have_prev_nxt = 1'b0;
      end else begin
        have_prev_nxt = 1'b1;
        prev_pt_nxt   = cur_pt;
        prev_w_nxt    = cur_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      closed_r    <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      closed_r    <= closed_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_pt_r  <= prev_pt_nxt;
    prev_w_r   <= prev_w_nxt;
    start_pt_r <= start_pt_nxt;
    start_w_r  <= start_w_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/wcc_seg_queue.sv
// Short segment queue between the front end and the cutting engine.
// Takes up to two segments per cycle, hands out one. Depends on wcc_pkg.
`default_nettype none
`include "weighted_corner_cutting_defines.svh"

module wcc_seg_queue import wcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  segq_wr_t segq_wr,
  output logic     segq_no_room,
  input  logic     segq_pop,
  output logic     segq_empty,
  output seg_t     segq_head
);

  seg_t               mem_r [SEGQ_DEPTH];
  logic [SEGQ_AW-1:0] wptr_r, wptr_nxt;
  logic [SEGQ_AW-1:0] rptr_r, rptr_nxt;
  logic [SEGQ_CW-1:0] cnt_r, cnt_nxt;
  logic [SEGQ_AW-1:0] wptr_p1;
  logic               do_pop;

  assign segq_empty   = (cnt_r == '0);
  assign segq_no_room = (cnt_r > SEGQ_CW'(SEGQ_DEPTH - 2));
  assign segq_head    = mem_r[rptr_r];
  assign do_pop       = segq_pop & ~segq_empty;
  assign wptr_p1      = SEGQ_AW'(wptr_r + 1'b1);

  always_comb begin
    wptr_nxt = SEGQ_AW'(wptr_r + SEGQ_AW'(segq_wr.n));
    rptr_nxt = do_pop ? SEGQ_AW'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = SEGQ_CW'(cnt_r + SEGQ_CW'(segq_wr.n) - SEGQ_CW'(do_pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (segq_wr.n != 2'd0) begin
      mem_r[wptr_r] <= segq_wr.first;
    end
    if (segq_wr.n == 2'd2) begin
      mem_r[wptr_p1] <= segq_wr.second;
    end
  end

  `WCC_ASSERT_ALWAYS(a_segq_bound, cnt_r <= SEGQ_CW'(SEGQ_DEPTH), "segment queue overfilled")
  `WCC_ASSERT_IMPLY(a_segq_room, segq_wr.n != 2'd0,
    (SEGQ_CW + 1)'(cnt_r) + (SEGQ_CW + 1)'(segq_wr.n) <= (SEGQ_CW + 1)'(SEGQ_DEPTH),
    "segment write without room")

endmodule

`default_nettype wire

>>> hdl/wcc_divider.sv
// Iterative restoring divider, four quotient bits per cycle.
// Divides a product of magnitude and weight by four times a weight. Depends on wcc_pkg.
`default_nettype none

module wcc_divider import wcc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [DIV_NUM_W-1:0]   num,
  input  logic [DEN_W-1:0]       den,
  output logic                   done,
  output logic [COORD_WIDTH-1:0] quo
);

  logic [DIV_PAD_W-1:0] num_r, num_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;

  logic [DIV_PAD_W-1:0] num_v;
  logic [DEN_W-1:0]     rem_v;
  logic [DEN_W:0]       t_v;

  // The remainder stays below the divisor, so each trial value fits DEN_W+1 bits.
  always_comb begin
    rem_v = rem_r;
    num_v = num_r;
    t_v   = '0;
    for (int i = 0; i < DIV_DIGITS; i++) begin
      t_v = {rem_v, num_v[DIV_PAD_W-1]};
      if (t_v >= {1'b0, den_r}) begin
        rem_v = DEN_W'(t_v - {1'b0, den_r});
        num_v = {num_v[DIV_PAD_W-2:0], 1'b1};
      end else begin
        rem_v = t_v[DEN_W-1:0];
        num_v = {num_v[DIV_PAD_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    done_nxt = (cnt_r == DIV_CNT_W'(1));
    if (start) begin
      num_nxt = DIV_PAD_W'(num);
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = DIV_CNT_W'(DIV_STEPS);
    end else if (cnt_r != '0) begin
      num_nxt = num_v;
      rem_nxt = rem_v;
      cnt_nxt = DIV_CNT_W'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = num_r[COORD_WIDTH-1:0];

endmodule

`default_nettype wire

>>> hdl/wcc_back.sv
// Cutting engine: takes one segment at a time, forms both new points axis by axis
// with the shared divider, and queues the results. Depends on wcc_pkg, wcc_divider.
`default_nettype none
`include "weighted_corner_cutting_defines.svh"

module wcc_back import wcc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  seg_t                    segq_head,
  input  logic                    segq_empty,
  output logic                    segq_pop,
  output logic                    empty,
  input  logic                    pop,
  output logic [COORD_WIDTH-1:0]  out_x,
  output logic [COORD_WIDTH-1:0]  out_y,
  output logic [COORD_WIDTH-1:0]  out_z,
  output logic [WEIGHT_WIDTH-1:0] out_weight,
  output logic                    out_run_end
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DIFF   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_EMIT_A = 3'd4;
  localparam logic [2:0] S_EMIT_B = 3'd5;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(NUM_AXES - 1);

  logic [2:0]              state_r, state_nxt;
  logic [AXIS_W-1:0]       axis_r, axis_nxt;
  seg_t                    seg_r, seg_nxt;
  logic                    lbig_r, lbig_nxt;
  logic [WEIGHT_WIDTH-1:0] wbig_r, wbig_nxt;
  logic [WEIGHT_WIDTH-1:0] wsmall_r, wsmall_nxt;
  logic                    neg_r, neg_nxt;
  logic [COORD_WIDTH-1:0]  mag_r, mag_nxt;
  point_t                  a_pt_r, a_pt_nxt;
  point_t                  b_pt_r, b_pt_nxt;

  result_t                 outq_r [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0]      outq_wptr_r, outq_wptr_nxt;
  logic [OUTQ_AW-1:0]      outq_rptr_r, outq_rptr_nxt;
  logic [OUTQ_CW-1:0]      outq_cnt_r, outq_cnt_nxt;
  logic                    outq_full;
  logic                    outq_wr;
  result_t                 outq_din;
  result_t                 outq_head;
  logic                    outq_rd;

  logic [COORD_WIDTH-1:0]  lp;
  logic [COORD_WIDTH-1:0]  rp;
  logic [COORD_WIDTH:0]    diff;
  logic [COORD_WIDTH:0]    diff_abs;
  logic                    div_start;
  logic                    div_done;
  logic [DIV_NUM_W-1:0]    div_num;
  logic [DEN_W-1:0]        div_den;
  logic [COORD_WIDTH-1:0]  div_quo;
  logic [COORD_WIDTH-1:0]  q_big;
  logic [COORD_WIDTH-1:0]  q_l;
  logic [COORD_WIDTH-1:0]  q_r;
  logic [COORD_WIDTH:0]    off_l;
  logic [COORD_WIDTH:0]    off_r;
  logic [COORD_WIDTH:0]    sum_a;
  logic [COORD_WIDTH:0]    sum_b;

  wcc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign lp       = seg_r.lpt[axis_r];
  assign rp       = seg_r.rpt[axis_r];
  assign diff     = {rp[COORD_WIDTH-1], rp} - {lp[COORD_WIDTH-1], lp};
  assign diff_abs = diff[COORD_WIDTH] ? ((COORD_WIDTH + 1)'(0) - diff) : diff;

  assign div_start = (state_r == S_MUL);
  assign div_num   = DIV_NUM_W'(mag_r) * DIV_NUM_W'(wsmall_r);
  assign div_den   = {wbig_r, 2'b00};

  // The side carrying the larger weight always moves by exactly a quarter of
  // the difference, so only the other side needs a real division.
  assign q_big = {2'b00, mag_r[COORD_WIDTH-1:2]};
  assign q_l   = lbig_r ? q_big : div_quo;
  assign q_r   = lbig_r ? div_quo : q_big;
  assign off_l = neg_r ? ((COORD_WIDTH + 1)'(0) - {1'b0, q_l}) : {1'b0, q_l};
  assign off_r = neg_r ? ((COORD_WIDTH + 1)'(0) - {1'b0, q_r}) : {1'b0, q_r};
  assign sum_a = {lp[COORD_WIDTH-1], lp} + off_l;
  assign sum_b = {rp[COORD_WIDTH-1], rp} - off_r;

  assign outq_full = (outq_cnt_r == OUTQ_CW'(OUTQ_DEPTH));

  always_comb begin
    state_nxt  = state_r;
    axis_nxt   = axis_r;
    seg_nxt    = seg_r;
    lbig_nxt   = lbig_r;
    wbig_nxt   = wbig_r;
    wsmall_nxt = wsmall_r;
    neg_nxt    = neg_r;
    mag_nxt    = mag_r;
    a_pt_nxt   = a_pt_r;
    b_pt_nxt   = b_pt_r;
    segq_pop   = 1'b0;
    outq_wr    = 1'b0;
    outq_din.pt      = a_pt_r;
    outq_din.w       = seg_r.lw;
    outq_din.run_end = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (!segq_empty) begin
          segq_pop   = 1'b1;
          seg_nxt    = segq_head;
          axis_nxt   = '0;
          lbig_nxt   = (segq_head.lw >= segq_head.rw);
          wbig_nxt   = (segq_head.lw >= segq_head.rw) ? segq_head.lw : segq_head.rw;
          wsmall_nxt = (segq_head.lw >= segq_head.rw) ? segq_head.rw : segq_head.lw;
          state_nxt  = S_DIFF;
        end
      end
      S_DIFF: begin
        neg_nxt   = diff[COORD_WIDTH];
        mag_nxt   = diff_abs[COORD_WIDTH-1:0];
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          a_pt_nxt[axis_r] = sum_a[COORD_WIDTH-1:0];
          b_pt_nxt[axis_r] = sum_b[COORD_WIDTH-1:0];
          if (axis_r == AXIS_LAST) begin
            state_nxt = S_EMIT_A;
          end else begin
            axis_nxt  = AXIS_W'(axis_r + 1'b1);
            state_nxt = S_DIFF;
          end
        end
      end
      S_EMIT_A: begin
        if (!outq_full) begin
          outq_wr   = 1'b1;
          state_nxt = S_EMIT_B;
        end
      end
      S_EMIT_B: begin
        outq_din.pt      = b_pt_r;
        outq_din.w       = seg_r.rw;
        outq_din.run_end = seg_r.last;
        if (!outq_full) begin
          outq_wr   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign empty     = (outq_cnt_r == '0);
  assign outq_rd   = pop & ~empty;
  assign outq_head = outq_r[outq_rptr_r];

  assign out_x       = outq_head.pt[0];
  assign out_y       = outq_head.pt[1];
  assign out_z       = outq_head.pt[2];
  assign out_weight  = outq_head.w;
  assign out_run_end = outq_head.run_end;

  always_comb begin
    outq_wptr_nxt = outq_wr ? OUTQ_AW'(outq_wptr_r + 1'b1) : outq_wptr_r;
    outq_rptr_nxt = outq_rd ? OUTQ_AW'(outq_rptr_r + 1'b1) : outq_rptr_r;
    outq_cnt_nxt  = OUTQ_CW'(outq_cnt_r + OUTQ_CW'(outq_wr) - OUTQ_CW'(outq_rd));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      axis_r      <= '0;
      outq_wptr_r <= '0;
      outq_rptr_r <= '0;
      outq_cnt_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      outq_wptr_r <= outq_wptr_nxt;
      outq_rptr_r <= outq_rptr_nxt;
      outq_cnt_r  <= outq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seg_r    <= seg_nxt;
    lbig_r   <= lbig_nxt;
    wbig_r   <= wbig_nxt;
    wsmall_r <= wsmall_nxt;
    neg_r    <= neg_nxt;
    mag_r    <= mag_nxt;
    a_pt_r   <= a_pt_nxt;
    b_pt_r   <= b_pt_nxt;
    if (outq_wr) begin
      outq_r[outq_wptr_r] <= outq_din;
    end
  end

  `WCC_ASSERT_IMPLY(a_done_in_wait, div_done, state_r == S_DIV,
    "divider finished outside its wait state")
  `WCC_ASSERT_IMPLY(a_outq_room, outq_wr, outq_cnt_r != OUTQ_CW'(OUTQ_DEPTH),
    "result written into a full queue")

endmodule

`default_nettype wire

>>> sim/weighted_corner_cutting_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for weighted_corner_cutting: directed polylines, then random ones.
// Depends on wcc_pkg and the RTL top; holds its own predictor of the cut points.

module weighted_corner_cutting_tb;
  import wcc_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One point, used both for input beats and for expected result beats.
  typedef struct packed {
    coord_t                  x;
    coord_t                  y;
    coord_t                  z;
    logic [WEIGHT_WIDTH-1:0] w;
    logic                    last;
  } beat_t;

  typedef enum {BY_MODEL, NONE_OUT, TWIN_OUT} row_kind_t;

  typedef struct {
    coord_t                  x;
    coord_t                  y;
    coord_t                  z;
    logic [WEIGHT_WIDTH-1:0] w;
    logic                    last;
    logic                    closed;
    row_kind_t               kind;
  } dir_row_t;

  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam int SETTLE_CYCLES = 150;
  localparam int STALL_LIMIT   = 3000;
  localparam int PHASE_POINTS  = 50;

  logic                    clk;
  logic                    rst_n           = 1'b0;
  logic                    psel            = 1'b0;
  logic                    penable         = 1'b0;
  logic                    pwrite          = 1'b0;
  logic [CFG_ADDR_W-1:0]   paddr           = '0;
  logic [CFG_DATA_W-1:0]   pwdata          = '0;
  logic [CFG_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    push            = 1'b0;
  logic                    full;
  logic [COORD_WIDTH-1:0]  in_x_coord      = '0;
  logic [COORD_WIDTH-1:0]  in_y_coord      = '0;
  logic [COORD_WIDTH-1:0]  in_z_coord      = '0;
  logic [WEIGHT_WIDTH-1:0] in_point_weight = '0;
  logic                    in_last_point   = 1'b0;
  logic                    empty;
  logic                    pop             = 1'b0;
  logic [COORD_WIDTH-1:0]  out_x;
  logic [COORD_WIDTH-1:0]  out_y;
  logic [COORD_WIDTH-1:0]  out_z;
  logic [WEIGHT_WIDTH-1:0] out_weight;
  logic                    out_run_end;

  // Predictor state.
  logic  closed_mode = 1'b0;
  logic  have_prev   = 1'b0;
  beat_t prev_pt;
  beat_t start_pt;

  beat_t pending_pts [$];
  beat_t new_pts [$];
  int    err_cnt     = 0;
  int    quiet_cycles = 0;
  int    gap_pct     = 0;
  int    stall_pct   = 0;

  dir_row_t dir_rows [14] = '{
    '{0, 0, 0, 5, 1'b0, 1'b0, NONE_OUT},              // first point after reset
    '{CMAX, CMAX, CMAX, 5, 1'b0, 1'b0, BY_MODEL},
    '{CMIN, CMIN, CMIN, 0, 1'b0, 1'b0, BY_MODEL},     // zero weight, full-scale swing
    '{CMAX, CMIN, CMAX, 255, 1'b0, 1'b0, BY_MODEL},
    '{CMIN, CMAX, CMIN, 1, 1'b1, 1'b0, BY_MODEL},     // last point, open loop
    '{123, -456, 789, 7, 1'b1, 1'b0, NONE_OUT},       // lone point, open loop
    '{256, -512, 768, 0, 1'b1, 1'b1, TWIN_OUT},       // lone point, closed loop
    '{CMAX, CMIN, 0, 255, 1'b0, 1'b1, NONE_OUT},
    '{CMIN, CMAX, 0, 128, 1'b0, 1'b1, BY_MODEL},
    '{4096, 8192, -12288, 3, 1'b1, 1'b1, BY_MODEL},   // closing segment, four beats
    '{CMIN, CMIN, CMIN, 255, 1'b0, 1'b1, NONE_OUT},
    '{CMAX, CMAX, CMAX, 255, 1'b1, 1'b1, BY_MODEL},
    '{-1, -1, -1, 0, 1'b0, 1'b1, NONE_OUT},
    '{1, 1, 1, 255, 1'b1, 1'b1, BY_MODEL}
  };

  weighted_corner_cutting u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .push            (push),
    .full            (full),
    .in_x_coord      (in_x_coord),
    .in_y_coord      (in_y_coord),
    .in_z_coord      (in_z_coord),
    .in_point_weight (in_point_weight),
    .in_last_point   (in_last_point),
    .empty           (empty),
    .pop             (pop),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_z           (out_z),
    .out_weight      (out_weight),
    .out_run_end     (out_run_end)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offset along one axis, truncated toward zero.
  function automatic longint trunc_part(input longint d, input longint w, input longint den);
    if (d < 0) return -(((-d) * w) / den);
    return (d * w) / den;
  endfunction

  task automatic cut_segment(input beat_t l, input beat_t r);
    beat_t  a;
    beat_t  b;
    longint den;
    longint dx;
    longint dy;
    longint dz;
    longint wl;
    longint wr;
    wl  = longint'(l.w);
    wr  = longint'(r.w);
    den = 4 * ((wl > wr) ? wl : wr);
    dx  = longint'($signed(r.x)) - longint'($signed(l.x));
    dy  = longint'($signed(r.y)) - longint'($signed(l.y));
    dz  = longint'($signed(r.z)) - longint'($signed(l.z));
    a.x = coord_t'(longint'($signed(l.x)) + trunc_part(dx, wl, den));
    a.y = coord_t'(longint'($signed(l.y)) + trunc_part(dy, wl, den));
    a.z = coord_t'(longint'($signed(l.z)) + trunc_part(dz, wl, den));
    b.x = coord_t'(longint'($signed(r.x)) - trunc_part(dx, wr, den));
    b.y = coord_t'(longint'($signed(r.y)) - trunc_part(dy, wr, den));
    b.z = coord_t'(longint'($signed(r.z)) - trunc_part(dz, wr, den));
    a.w    = l.w;
    a.last = 1'b0;
    b.w    = r.w;
    b.last = 1'b0;
    new_pts.insert(new_pts.size(), a);
    new_pts.insert(new_pts.size(), b);
  endtask

  // Cut points caused by one accepted point; they land in new_pts.
  task automatic predict_cuts(input beat_t p);
    beat_t cur;
    cur = p;
    cur.last = 1'b0;
    if (cur.w == '0) cur.w = WEIGHT_WIDTH'(1);
    new_pts.delete();
    if (have_prev) cut_segment(prev_pt, cur);
    else start_pt = cur;
    if (p.last) begin
      if (closed_mode) cut_segment(cur, start_pt);
      have_prev = 1'b0;
    end else begin
      prev_pt   = cur;
      have_prev = 1'b1;
    end
    if (new_pts.size() > 0) new_pts[new_pts.size()-1].last = 1'b1;
  endtask

  task automatic send_point(input beat_t p, input row_kind_t kind);
    beat_t twin;
    in_x_coord      <= p.x;
    in_y_coord      <= p.y;
    in_z_coord      <= p.z;
    in_point_weight <= p.w;
    in_last_point   <= p.last;
    push            <= 1'b1;
    do @(posedge clk); while (full !== 1'b0);
    predict_cuts(p);
    case (kind)
      BY_MODEL: foreach (new_pts[i]) pending_pts.insert(pending_pts.size(), new_pts[i]);
      TWIN_OUT: begin
        twin      = p;
        twin.w    = (p.w == '0) ? WEIGHT_WIDTH'(1) : p.w;
        twin.last = 1'b0;
        pending_pts.insert(pending_pts.size(), twin);
        twin.last = 1'b1;
        pending_pts.insert(pending_pts.size(), twin);
      end
      default: ;
    endcase
    if ($urandom_range(99) < gap_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
  endtask

  // Hold off the sender until the block has drained and gone quiet.
  task automatic settle();
    push <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    closed_mode = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata[0] !== val) begin
      $error("closed_curve readback: expected %0d, got %0d", val, prdata[0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic coord_t rand_coord(input coord_t near);
    case ($urandom_range(7))
      0:       return CMAX;
      1:       return CMIN;
      2, 3:    return near + coord_t'($urandom_range(4095)) - coord_t'(2048);
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [WEIGHT_WIDTH-1:0] rand_weight();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_WIDTH'(1);
      default: return WEIGHT_WIDTH'($urandom());
    endcase
  endfunction

  task automatic send_polyline(input int len);
    beat_t p;
    p = '0;
    for (int i = 0; i < len; i++) begin
      p.x    = rand_coord(p.x);
      p.y    = rand_coord(p.y);
      p.z    = rand_coord(p.z);
      p.w    = rand_weight();
      p.last = (i == len - 1);
      send_point(p, BY_MODEL);
    end
  endtask

  task automatic check_beat();
    beat_t want;
    if (pending_pts.size() == 0) begin
      $error("result beat with nothing expected: x=%0d y=%0d z=%0d",
             $signed(out_x), $signed(out_y), $signed(out_z));
      err_cnt++;
    end else begin
      want = pending_pts.pop_front();
      if (out_x !== want.x) begin
        $error("out_x: expected %0d, got %0d", $signed(want.x), $signed(out_x));
        err_cnt++;
      end
      if (out_y !== want.y) begin
        $error("out_y: expected %0d, got %0d", $signed(want.y), $signed(out_y));
        err_cnt++;
      end
      if (out_z !== want.z) begin
        $error("out_z: expected %0d, got %0d", $signed(want.z), $signed(out_z));
        err_cnt++;
      end
      if (out_weight !== want.w) begin
        $error("out_weight: expected %0d, got %0d", want.w, out_weight);
        err_cnt++;
      end
      if (out_run_end !== want.last) begin
        $error("out_run_end: expected %0d, got %0d", want.last, out_run_end);
        err_cnt++;
      end
    end
  endtask

  // Result side: check each popped beat, stall at random, and track quiet cycles.
  always @(posedge clk) begin
    if (rst_n) begin
      if (pop && empty === 1'b0) check_beat();
      if ((push && full === 1'b0) || (pop && empty === 1'b0)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    beat_t pt;
    int    sent;
    int    len;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].closed != closed_mode) begin
        settle();
        reg_write(REG_CLOSED_CURVE, dir_rows[i].closed);
      end
      pt.x    = dir_rows[i].x;
      pt.y    = dir_rows[i].y;
      pt.z    = dir_rows[i].z;
      pt.w    = dir_rows[i].w;
      pt.last = dir_rows[i].last;
      send_point(pt, dir_rows[i].kind);
    end

    // Each flow-control pattern runs once per curve mode.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      reg_write(REG_CLOSED_CURVE, ph[0]);
      case (ph >> 1)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 57; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 57; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase
      sent = 0;
      while (sent < PHASE_POINTS) begin
        len = ($urandom_range(9) == 0) ? 1 : $urandom_range(7, 2);
        send_polyline(len);
        sent += len;
      end
    end

    settle();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> weighted_corner_cutting.f
+incdir+hdl
hdl/wcc_pkg.sv
hdl/wcc_front.sv
hdl/wcc_seg_queue.sv
hdl/wcc_divider.sv
hdl/wcc_back.sv
hdl/weighted_corner_cutting.sv
sim/weighted_corner_cutting_tb.sv
